FILE: rtl/sdbc_pkg.sv
// Package for the simplified DES byte cipher: permutation tables, S-boxes,
// the subkey pair type and the permutation and S-box helper functions.
// No dependencies.
package sdbc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 10;
  localparam int unsigned HalfW = 4;

  // Configuration register indexes.
  localparam logic CFG_IDX_KEY  = 1'b0;
  localparam logic CFG_IDX_MODE = 1'b1;

  // Entry t at position i: output bit i takes input bit t.
  localparam logic [2:0] IP_TAB  [8]  = '{3'd1, 3'd5, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4, 3'd6};
  localparam logic [2:0] FP_TAB  [8]  = '{3'd3, 3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd7, 3'd5};
  localparam logic [1:0] EP_TAB  [8]  = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0};
  localparam logic [1:0] P4_TAB  [4]  = '{2'd1, 2'd3, 2'd2, 2'd0};
  localparam logic [3:0] P10_TAB [10] = '{4'd2, 4'd4, 4'd1, 4'd6, 4'd3,
                                          4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
  localparam logic [3:0] P8_TAB  [8]  = '{4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd4, 4'd9, 4'd8};

  localparam logic [1:0] SB_LO [4][4] = '{'{2'd1, 2'd0, 2'd3, 2'd2},
                                          '{2'd3, 2'd2, 2'd1, 2'd0},
                                          '{2'd0, 2'd2, 2'd1, 2'd3},
                                          '{2'd3, 2'd1, 2'd3, 2'd2}};
  localparam logic [1:0] SB_HI [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                          '{2'd2, 2'd0, 2'd1, 2'd3},
                                          '{2'd3, 2'd0, 2'd1, 2'd0},
                                          '{2'd2, 2'd1, 2'd0, 2'd3}};

  typedef struct packed {
    logic [ByteW-1:0] first;
    logic [ByteW-1:0] second;
  } subkeys_t;

  function automatic logic [ByteW-1:0] ip_perm(logic [ByteW-1:0] src);
    logic [ByteW-1:0] res;
    for (int i = 0; i < 8; i++) res[i] = src[IP_TAB[i]];
    return res;
  endfunction

  function automatic logic [ByteW-1:0] fp_perm(logic [ByteW-1:0] src);
    logic [ByteW-1:0] res;
    for (int i = 0; i < 8; i++) res[i] = src[FP_TAB[i]];
    return res;
  endfunction

  function automatic logic [ByteW-1:0] ep_perm(logic [HalfW-1:0] src);
    logic [ByteW-1:0] res;
    for (int i = 0; i < 8; i++) res[i] = src[EP_TAB[i]];
    return res;
  endfunction

  function automatic logic [HalfW-1:0] p4_perm(logic [HalfW-1:0] src);
    logic [HalfW-1:0] res;
    for (int i = 0; i < 4; i++) res[i] = src[P4_TAB[i]];
    return res;
  endfunction

  function automatic logic [KeyW-1:0] p10_perm(logic [KeyW-1:0] src);
    logic [KeyW-1:0] res;
    for (int i = 0; i < 10; i++) res[i] = src[P10_TAB[i]];
    return res;
  endfunction

  function automatic logic [ByteW-1:0] p8_perm(logic [KeyW-1:0] src);
    logic [ByteW-1:0] res;
    for (int i = 0; i < 8; i++) res[i] = src[P8_TAB[i]];
    return res;
  endfunction

  // Row comes from the outer bits of the nibble, column from the inner bits.
  function automatic logic [1:0] sbox_lo(logic [HalfW-1:0] nib);
    return SB_LO[{nib[3], nib[0]}][{nib[2], nib[1]}];
  endfunction

  function automatic logic [1:0] sbox_hi(logic [HalfW-1:0] nib);
    return SB_HI[{nib[3], nib[0]}][{nib[2], nib[1]}];
  endfunction

endpackage

FILE: rtl/sdbc_key_sched.sv
// Subkey schedule of the simplified DES byte cipher: P10, per-half rotation
// by one twice, P8 for each subkey, and ordering by mode. Uses sdbc_pkg.
module sdbc_key_sched import sdbc_pkg::*; (
  input  logic [KeyW-1:0] key_i,
  input  logic            decrypt_i,
  output subkeys_t        subkeys_o
);

  logic [KeyW-1:0]  p10;
  logic [4:0]       kl1, kr1, kl2, kr2;
  logic [ByteW-1:0] sk1, sk2;

  assign p10 = p10_perm(key_i);
  assign kl1 = {p10[3:0], p10[4]};
  assign kr1 = {p10[8:5], p10[9]};
  assign kl2 = {kl1[3:0], kl1[4]};
  assign kr2 = {kr1[3:0], kr1[4]};
  assign sk1 = p8_perm({kr1, kl1});
  assign sk2 = p8_perm({kr2, kl2});

  // Decryption runs the rounds with the subkeys in reverse order.
  always_comb begin
    if (decrypt_i) begin
      subkeys_o.first  = sk2;
      subkeys_o.second = sk1;
    end else begin
      subkeys_o.first  = sk1;
      subkeys_o.second = sk2;
    end
  end

endmodule

FILE: rtl/sdbc_round.sv
// One Feistel round function of the simplified DES byte cipher: expansion,
// subkey XOR, two S-boxes and P4. Uses sdbc_pkg.
module sdbc_round import sdbc_pkg::*; (
  input  logic [HalfW-1:0] half_i,
  input  logic [ByteW-1:0] subkey_i,
  output logic [HalfW-1:0] f_o
);

  logic [ByteW-1:0] x;
  logic [1:0]       lo, hi;

  assign x   = ep_perm(half_i) ^ subkey_i;
  assign lo  = sbox_lo(x[3:0]);
  assign hi  = sbox_hi(x[7:4]);
  assign f_o = p4_perm({hi, lo});

endmodule

FILE: rtl/simplified_des_byte_cipher.sv
// Top level of the simplified DES byte cipher: configuration registers,
// input register, two rounds and result register.
// Uses sdbc_pkg, sdbc_key_sched and sdbc_round.
//
// Usage:
//   Input: a byte on data_in_i is transferred at a rising edge with start
//   high and busy low. busy is always low, so a byte may be sent every cycle.
//   Output: each result appears on data_out_o for exactly one cycle with
//   done_o high, in input order. The receiver has no way to stall the block
//   and must take every result. Throughput is one byte per cycle; the input
//   register and the result register lie around the two rounds.
//   Configuration: cfg_we_i with cfg_idx_i writes cfg_wdata_i to the key
//   (index 0, ten bits) or to the decrypt mode (index 1, low bit). Write
//   only while no byte is in flight.
//   Reset: both configuration registers clear to zero (encrypt, key zero)
//   and no result is pending.
module simplified_des_byte_cipher import sdbc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [ByteW-1:0] data_in_i,
  output logic             done_o,
  output logic [ByteW-1:0] data_out_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [KeyW-1:0]  cfg_wdata_i
);

  logic [KeyW-1:0]  key_q;
  logic             decrypt_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_data_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_data_q, out_data_d;
  subkeys_t         subkeys;
  logic [ByteW-1:0] blk;
  logic [HalfW-1:0] f1, f2, mid, fin;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_KEY:  key_q     <= cfg_wdata_i;
        CFG_IDX_MODE: decrypt_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start && !busy;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_data_q <= data_in_i;
    end
    if (in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  sdbc_key_sched u_key_sched (
    .key_i     (key_q),
    .decrypt_i (decrypt_q),
    .subkeys_o (subkeys)
  );

  assign blk = ip_perm(in_data_q);

  sdbc_round u_round1 (
    .half_i   (blk[7:4]),
    .subkey_i (subkeys.first),
    .f_o      (f1)
  );

  assign mid = blk[3:0] ^ f1;

  sdbc_round u_round2 (
    .half_i   (mid),
    .subkey_i (subkeys.second),
    .f_o      (f2)
  );

  assign fin = blk[7:4] ^ f2;

  // The halves are swapped between the rounds, so mid lands in the upper nibble.
  assign out_data_d = fp_perm({mid, fin});

  assign done_o     = out_valid_q;
  assign data_out_o = out_data_q;

endmodule

FILE: bench/tb.sv
// Self-checking testbench for simplified_des_byte_cipher: random and directed bytes
// against a local S-DES predictor, with key and mode changes between drained phases.
// Depends on rtl/sdbc_pkg.sv and rtl/simplified_des_byte_cipher.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdbc_pkg::ByteW;
  import sdbc_pkg::KeyW;
  import sdbc_pkg::CFG_IDX_KEY;
  import sdbc_pkg::CFG_IDX_MODE;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned PIPE_DEPTH   = 2;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned STALL_LIMIT  = 200;

  // Entry i of a map names the source bit of result bit i; unused entries are padding.
  typedef logic [0:9][3:0] bit_map_t;
  typedef logic [0:3][0:3][1:0] sbox_map_t;

  localparam bit_map_t IP_MAP  = '{4'd1, 4'd5, 4'd2, 4'd0, 4'd3, 4'd7, 4'd4, 4'd6, 4'd0, 4'd0};
  localparam bit_map_t FP_MAP  = '{4'd3, 4'd0, 4'd2, 4'd4, 4'd6, 4'd1, 4'd7, 4'd5, 4'd0, 4'd0};
  localparam bit_map_t EP_MAP  = '{4'd3, 4'd0, 4'd1, 4'd2, 4'd1, 4'd2, 4'd3, 4'd0, 4'd0, 4'd0};
  localparam bit_map_t P4_MAP  = '{4'd1, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
  localparam bit_map_t P10_MAP = '{4'd2, 4'd4, 4'd1, 4'd6, 4'd3, 4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
  localparam bit_map_t P8_MAP  = '{4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd4, 4'd9, 4'd8, 4'd0, 4'd0};

  localparam sbox_map_t LOW_BOX  = '{'{2'd1, 2'd0, 2'd3, 2'd2},
                                     '{2'd3, 2'd2, 2'd1, 2'd0},
                                     '{2'd0, 2'd2, 2'd1, 2'd3},
                                     '{2'd3, 2'd1, 2'd3, 2'd2}};
  localparam sbox_map_t HIGH_BOX = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                     '{2'd2, 2'd0, 2'd1, 2'd3},
                                     '{2'd3, 2'd0, 2'd1, 2'd0},
                                     '{2'd2, 2'd1, 2'd0, 2'd3}};

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  logic [ByteW-1:0] data_in_i   = '0;
  logic             done_o;
  logic [ByteW-1:0] data_out_o;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_idx_i   = CFG_IDX_KEY;
  logic [KeyW-1:0]  cfg_wdata_i = '0;

  // Copy of the configuration as the block should hold it.
  logic [KeyW-1:0]  key_shadow  = '0;
  logic             mode_shadow = 1'b0;

  logic [ByteW-1:0] pending_bytes[$];
  logic [ByteW-1:0] expected_bytes[$];

  logic        bursts_on   = 1'b0;
  int unsigned gap_left    = 0;
  int unsigned stall_count = 0;
  int unsigned error_count = 0;
  int unsigned accepted    = 0;
  int unsigned checked     = 0;
  int unsigned settings    = 0;
  int unsigned drains      = 0;

  simplified_des_byte_cipher u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .data_in_i  (data_in_i),
    .done_o     (done_o),
    .data_out_o (data_out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  function automatic logic [9:0] permute(input logic [9:0] src, input bit_map_t map,
                                         input int width);
    logic [9:0] res;
    res = '0;
    for (int i = 0; i < width; i++) res[i] = src[map[i]];
    return res;
  endfunction

  // Row from the outer nibble bits, column from the inner ones.
  function automatic logic [1:0] sbox_lookup(input sbox_map_t box, input logic [3:0] nib);
    return box[{nib[3], nib[0]}][{nib[2], nib[1]}];
  endfunction

  function automatic logic [3:0] round_mix(input logic [3:0] half, input logic [7:0] subkey);
    logic [9:0] spread;
    logic [7:0] mixed;
    logic [1:0] lo_bits;
    logic [1:0] hi_bits;
    logic [9:0] shuffled;
    spread   = permute({6'd0, half}, EP_MAP, 8);
    mixed    = spread[7:0] ^ subkey;
    lo_bits  = sbox_lookup(LOW_BOX, mixed[3:0]);
    hi_bits  = sbox_lookup(HIGH_BOX, mixed[7:4]);
    shuffled = permute({6'd0, hi_bits, lo_bits}, P4_MAP, 4);
    return shuffled[3:0];
  endfunction

  function automatic logic [ByteW-1:0] sdes_transform(input logic [KeyW-1:0] cipher_key,
                                                      input logic decrypt,
                                                      input logic [ByteW-1:0] din);
    logic [9:0] tmp;
    logic [4:0] lo_half;
    logic [4:0] hi_half;
    logic [7:0] sub1;
    logic [7:0] sub2;
    logic [7:0] first_key;
    logic [7:0] second_key;
    logic [3:0] left;
    logic [3:0] right;
    logic [3:0] mid;
    logic [3:0] fin;
    tmp     = permute(cipher_key, P10_MAP, 10);
    // Both halves rotate left by one for each subkey, not by two for the second.
    lo_half = {tmp[3:0], tmp[4]};
    hi_half = {tmp[8:5], tmp[9]};
    tmp     = permute({hi_half, lo_half}, P8_MAP, 8);
    sub1    = tmp[7:0];
    lo_half = {lo_half[3:0], lo_half[4]};
    hi_half = {hi_half[3:0], hi_half[4]};
    tmp     = permute({hi_half, lo_half}, P8_MAP, 8);
    sub2    = tmp[7:0];
    if (decrypt) begin
      first_key  = sub2;
      second_key = sub1;
    end else begin
      first_key  = sub1;
      second_key = sub2;
    end
    tmp   = permute({2'b00, din}, IP_MAP, 8);
    left  = tmp[3:0];
    right = tmp[7:4];
    mid   = left ^ round_mix(right, first_key);
    fin   = right ^ round_mix(mid, second_key);
    tmp   = permute({2'b00, mid, fin}, FP_MAP, 8);
    return tmp[7:0];
  endfunction

  task automatic log_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  // Driver: presents the oldest pending byte, with random idle bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (bursts_on && pending_bytes.size() != 0 && $urandom_range(0, 11) == 0) begin
      gap_left = $urandom_range(0, 14);
      start <= 1'b0;
    end else if (pending_bytes.size() != 0) begin
      start     <= 1'b1;
      data_in_i <= pending_bytes[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks results first, then records the input transfer of this edge.
  always @(posedge clk_i) begin : monitor_proc
    logic             moved;
    logic [ByteW-1:0] want;
    if (rst_ni) begin
      moved = 1'b0;
      if (done_o) begin
        moved = 1'b1;
        if (expected_bytes.size() == 0) begin
          log_mismatch($sformatf("result 0x%02h arrived with nothing outstanding", data_out_o));
        end else begin
          want = expected_bytes.pop_front();
          checked++;
          if (data_out_o !== want)
            log_mismatch($sformatf("data_out 0x%02h, predicted 0x%02h", data_out_o, want));
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        expected_bytes.push_back(sdes_transform(key_shadow, mode_shadow, data_in_i));
        if (pending_bytes.size() != 0) void'(pending_bytes.pop_front());
        accepted++;
      end
      if (moved) begin
        stall_count = 0;
      end else begin
        stall_count++;
        if (stall_count >= STALL_LIMIT) begin
          $display("[%0t] ERROR: no transfer for %0d cycles", $realtime, STALL_LIMIT);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [KeyW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_IDX_KEY) key_shadow = val;
    else mode_shadow = val[0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Lets the pipeline run empty before the configuration may change.
  task automatic settle();
    while (pending_bytes.size() != 0 || expected_bytes.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 2) @(negedge clk_i);
    drains++;
  endtask

  initial begin : stimulus
    logic [ByteW-1:0] edge_bytes[6];
    logic [KeyW-1:0]  new_key;
    logic [KeyW-1:0]  new_mode;
    logic [ByteW-1:0] value;
    int unsigned      random_sent;
    int unsigned      phase_len;
    edge_bytes  = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA};
    random_sent = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset configuration, then all-ones key with wide mode values, then key zero in decrypt mode.
    settings++;
    foreach (edge_bytes[i]) pending_bytes.push_back(edge_bytes[i]);
    settle();
    write_reg(CFG_IDX_KEY, '1);
    write_reg(CFG_IDX_MODE, '1);
    settings++;
    foreach (edge_bytes[i]) pending_bytes.push_back(edge_bytes[i]);
    settle();
    write_reg(CFG_IDX_MODE, 10'h2AA);
    settings++;
    for (int i = 0; i < 4; i++) pending_bytes.push_back(edge_bytes[i]);
    settle();
    write_reg(CFG_IDX_KEY, '0);
    write_reg(CFG_IDX_MODE, 10'h001);
    settings++;
    for (int i = 0; i < 4; i++) pending_bytes.push_back(edge_bytes[i]);

    // Random phases, each of which may change the key and the mode; the tail runs without gaps.
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       new_key = '0;
          1:       new_key = '1;
          default: new_key = KeyW'($urandom());
        endcase
        write_reg(CFG_IDX_KEY, new_key);
      end
      if ($urandom_range(0, 1) != 0) begin
        new_mode = KeyW'($urandom());
        write_reg(CFG_IDX_MODE, new_mode);
      end
      settings++;
      phase_len = $urandom_range(20, 120);
      if (phase_len > RANDOM_ITEMS - random_sent) phase_len = RANDOM_ITEMS - random_sent;
      bursts_on = (RANDOM_ITEMS - random_sent > 200) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 7) == 0) value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else value = ByteW'($urandom_range(0, 255));
        pending_bytes.push_back(value);
      end
      random_sent += phase_len;
    end

    settle();
    $display("Covered %0d byte transfers and %0d checked results under %0d configurations,",
             accepted, checked, settings);
    $display("with %0d full pipeline drains and %0d errors logged.", drains, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
